FILE: sv/lfsr_filter_keystream_word_assert.svh
// ----------------------------------------------------------------------------
// lfsr filter keystream word assertion macros
// concurrent assertion shorthands on clk with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef LFSR_FILTER_KEYSTREAM_WORD_ASSERT_SVH
`define LFSR_FILTER_KEYSTREAM_WORD_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LFKW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfkw assertion failed");

// next-cycle implication
`define LFKW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfkw assertion failed");

`else

`define LFKW_ASSERT_IMP(lbl, ante, cons)
`define LFKW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: sv/lfkw_pkg.sv
// ----------------------------------------------------------------------------
// lfkw_pkg
// constants, tables and round functions of the filtered 48-bit lfsr
// ----------------------------------------------------------------------------
package lfkw_pkg;

  localparam int KEY_W    = 48;
  localparam int SERIAL_W = 32;
  localparam int NONCE_W  = 32;
  localparam int WORD_W   = 32;
  localparam int STATE_W  = 48;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 4;

  // round schedule: init rounds, discarded rounds, output rounds
  localparam int NUM_INIT    = 32;
  localparam int NUM_SKIP    = 32;
  localparam int NUM_OUT     = WORD_W;
  localparam int NUM_RND     = NUM_INIT + NUM_SKIP + NUM_OUT;
  localparam int RND_PER_STG = 8;
  localparam int NUM_STG     = NUM_RND / RND_PER_STG;
  localparam int IV_IDX_W    = $clog2(NUM_INIT);

  // register select is address bit 3 (8-byte register spacing)
  localparam logic REG_KEY    = 1'b0;
  localparam logic REG_SERIAL = 1'b1;

  // filter tables
  localparam logic [15:0] TAB_A = 16'h2C79;
  localparam logic [15:0] TAB_B = 16'h6671;
  localparam logic [31:0] TAB_C = 32'h7907287B;

  // feedback taps 0,2,3,6,7,8,16,22,23,26,30,41,42,43,46,47
  localparam logic [STATE_W-1:0] FB_TAPS = 48'hCE00_44C1_01CD;

  typedef logic [STATE_W-1:0] state_t;

  function automatic logic filt(input state_t x);
    logic [4:0] idx;
    idx[0] = TAB_A[{x[5],  x[4],  x[2],  x[1]}];
    idx[1] = TAB_B[{x[14], x[13], x[11], x[7]}];
    idx[2] = TAB_B[{x[25], x[22], x[20], x[16]}];
    idx[3] = TAB_B[{x[32], x[30], x[28], x[27]}];
    idx[4] = TAB_A[{x[45], x[43], x[42], x[33]}];
    return TAB_C[idx];
  endfunction

  // shift right, new top bit is filter of shifted state xor input bit
  function automatic state_t init_round(input state_t x, input logic inb);
    state_t xs;
    xs = {1'b0, x[STATE_W-1:1]};
    return {filt(xs) ^ inb, xs[STATE_W-2:0]};
  endfunction

  // plain lfsr step with fixed feedback
  function automatic state_t lfsr_next(input state_t x);
    logic fb;
    fb = ^(x & FB_TAPS);
    return {fb, x[STATE_W-1:1]};
  endfunction

endpackage

FILE: sv/lfsr_filter_keystream_word.sv
// ----------------------------------------------------------------------------
// lfsr_filter_keystream_word
// nonce in, 32-bit keystream word out, from a filtered 48-bit lfsr
// out_strobe rises when the taken nonce leaves the last of the pipeline stages
// throughput: one nonce per cycle, set by 12 pipeline stages of 8 rounds each
// busy stays low: results cannot be held off so the pipeline never stalls
// reset (synchronous, rst_n low): clears key, serial and all stage valid bits
// ----------------------------------------------------------------------------
module lfsr_filter_keystream_word (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [lfkw_pkg::NONCE_W-1:0]   in_nonce,
  // result channel
  output logic                           out_strobe,
  output logic [lfkw_pkg::WORD_W-1:0]    out_keystream_word,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfkw_pkg::ADDR_W-1:0]    paddr,
  input  logic [lfkw_pkg::CFG_W-1:0]     pwdata,
  output logic [lfkw_pkg::CFG_W-1:0]     prdata,
  output logic                           pready
);
  import lfkw_pkg::*;

  `include "lfsr_filter_keystream_word_assert.svh"

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]    secret_key_r;
  logic [SERIAL_W-1:0] tag_serial_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_key_r <= '0;
      tag_serial_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY:    secret_key_r <= pwdata[KEY_W-1:0];
        REG_SERIAL: tag_serial_r <= pwdata[SERIAL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY:    prdata = CFG_W'(secret_key_r);
      REG_SERIAL: prdata = CFG_W'(tag_serial_r);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // initial state: reversed key low 16 bits over reversed serial
  // reversed key bit i+16 is key bit 31-i, so init rounds read the low key word
  // --------------------------------------------------------------------------
  state_t              load_state;
  logic [15:0]         key_rev_lo;
  logic [SERIAL_W-1:0] ser_rev;
  logic [NONCE_W-1:0]  key_lo;

  always_comb begin
    for (int k = 0; k < 16; k++) key_rev_lo[k] = secret_key_r[KEY_W-1-k];
    for (int k = 0; k < SERIAL_W; k++) ser_rev[k] = tag_serial_r[SERIAL_W-1-k];
  end

  assign load_state = {key_rev_lo, ser_rev};
  assign key_lo     = secret_key_r[NONCE_W-1:0];

  // the pipeline always moves, so a new nonce can be taken every cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // round pipeline
  // aux carries the nonce through the init rounds and then collects the
  // output word; 32 shifts push out every stale bit before the word is read
  // --------------------------------------------------------------------------
  state_t             x_r    [NUM_STG];
  state_t             x_nxt  [NUM_STG];
  logic [WORD_W-1:0]  aux_r  [NUM_STG];
  logic [WORD_W-1:0]  aux_nxt[NUM_STG];
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;

  for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
    state_t            x_in;
    state_t            x_out;
    logic [WORD_W-1:0] aux_in;
    logic [WORD_W-1:0] aux_out;
    logic              vld_in;

    if (s == 0) begin : g_head
      // stage 0 takes the transfer straight from the command ports
      assign x_in   = load_state;
      assign aux_in = in_nonce;
      assign vld_in = start & ~busy;
    end else begin : g_body
      assign x_in   = x_r[s-1];
      assign aux_in = aux_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      state_t            x;
      logic [WORD_W-1:0] aux;
      int                r;
      x   = x_in;
      aux = aux_in;
      for (int j = 0; j < RND_PER_STG; j++) begin
        r = s * RND_PER_STG + j;
        if (r < NUM_INIT) begin
          // reversed nonce bit r is nonce bit 31-r
          x = init_round(x, aux[IV_IDX_W'(NUM_INIT - 1 - r)] ^
                            key_lo[IV_IDX_W'(NUM_INIT - 1 - r)]);
        end else if (r < NUM_INIT + NUM_SKIP) begin
          x = lfsr_next(x);
        end else begin
          x   = lfsr_next(x);
          aux = {aux[WORD_W-2:0], filt(x)};
        end
      end
      x_out   = x;
      aux_out = aux;
    end

    assign x_nxt[s]   = x_out;
    assign aux_nxt[s] = aux_out;
    assign vld_nxt[s] = vld_in;
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_STG; s++) begin
      x_r[s]   <= x_nxt[s];
      aux_r[s] <= aux_nxt[s];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // result transfer straight from the last stage
  assign out_strobe         = vld_r[NUM_STG-1];
  assign out_keystream_word = aux_r[NUM_STG-1];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `LFKW_ASSERT_IMP(a_no_orphan_result, out_strobe, $past(start, NUM_STG))
  `LFKW_ASSERT_IMP(a_result_follows, start && !busy, ##NUM_STG out_strobe)
  `LFKW_ASSERT_NXT(a_key_write, cfg_wr && (paddr[3] == REG_KEY),
                   secret_key_r == $past(pwdata[KEY_W-1:0]))
  `LFKW_ASSERT_NXT(a_serial_write, cfg_wr && (paddr[3] == REG_SERIAL),
                   tag_serial_r == $past(pwdata[SERIAL_W-1:0]))

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// keystream word generator bench: nonce transfers in, one 32-bit word out per
// nonce; every word is checked against its typed-in value or a bit-level copy of the cipher
// under the key and serial last written over the apb-style port
// ----------------------------------------------------------------------------
module tb_top;

  // bench timing and sizing
  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 40;   // pipeline is 12 deep, leave margin
  localparam int MAX_REPORTS     = 40;
  localparam int IDLE_PCT        = 9;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int QUIET_PHASE     = 4;    // phase run with no sender idling

  // register map: register select sits on address bit 3
  localparam logic [lfkw_pkg::ADDR_W-1:0] ADDR_KEY    = {lfkw_pkg::REG_KEY, 3'b000};
  localparam logic [lfkw_pkg::ADDR_W-1:0] ADDR_SERIAL = {lfkw_pkg::REG_SERIAL, 3'b000};

  // nonlinear filter tables of the cipher
  localparam logic [15:0] FILT_A = 16'h2C79;
  localparam logic [15:0] FILT_B = 16'h6671;
  localparam logic [31:0] FILT_C = 32'h7907287B;

  // one row of the directed table
  typedef struct {
    logic [63:0] key_raw;
    logic [63:0] serial_raw;
    logic [31:0] nonce;
    logic        known;    // word typed in below rather than predicted
    logic [31:0] word;
  } stim_row_t;

  localparam int DIR_ROWS = 18;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            start      = 1'b0;
  logic                            busy;
  logic [lfkw_pkg::NONCE_W-1:0]    in_nonce   = '0;
  logic                            out_strobe;
  logic [lfkw_pkg::WORD_W-1:0]     out_keystream_word;
  logic                            psel       = 1'b0;
  logic                            penable    = 1'b0;
  logic                            pwrite     = 1'b0;
  logic [lfkw_pkg::ADDR_W-1:0]     paddr      = '0;
  logic [lfkw_pkg::CFG_W-1:0]      pwdata     = '0;
  logic [lfkw_pkg::CFG_W-1:0]      prdata;
  logic                            pready;

  // bench copy of the configuration, raw as written and masked as held
  logic [63:0] key_raw_cur    = '0;
  logic [63:0] serial_raw_cur = '0;
  logic [47:0] key_reg        = '0;
  logic [31:0] serial_reg     = '0;

  // words still owed by the block, oldest first
  logic [31:0] pending_words[$];

  int          mismatches  = 0;
  int          quiet_cycles = 0;
  logic [31:0] oldest_word;
  stim_row_t   dir_rows [DIR_ROWS];

  lfsr_filter_keystream_word dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_nonce           (in_nonce),
    .out_strobe         (out_strobe),
    .out_keystream_word (out_keystream_word),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // cipher prediction
  // --------------------------------------------------------------------------

  // five 4-bit groups pick table bits that form the index into the final table
  function automatic logic filter_out(input logic [47:0] s);
    logic [4:0] sel;
    sel[0] = FILT_A[{s[5],  s[4],  s[2],  s[1]}];
    sel[1] = FILT_B[{s[14], s[13], s[11], s[7]}];
    sel[2] = FILT_B[{s[25], s[22], s[20], s[16]}];
    sel[3] = FILT_B[{s[32], s[30], s[28], s[27]}];
    sel[4] = FILT_A[{s[45], s[43], s[42], s[33]}];
    return FILT_C[sel];
  endfunction

  function automatic logic [31:0] predict_keystream(input logic [47:0] key,
                                                    input logic [31:0] serial,
                                                    input logic [31:0] nonce);
    logic [47:0] key_rev;
    logic [47:0] st;
    logic [31:0] serial_rev;
    logic [31:0] nonce_rev;
    logic [31:0] word;
    logic        fb;
    for (int k = 0; k < 48; k++) key_rev[47-k] = key[k];
    for (int k = 0; k < 32; k++) begin
      serial_rev[31-k] = serial[k];
      nonce_rev[31-k]  = nonce[k];
    end
    st = {key_rev[15:0], serial_rev};
    // initialization: nonce and low key word folded in through the filter
    for (int r = 0; r < 32; r++) begin
      st     = st >> 1;
      st[47] = filter_out(st) ^ nonce_rev[r] ^ key_rev[r+16];
    end
    // free-running lfsr; first 32 filter bits thrown away, next 32 kept msb first
    word = '0;
    for (int r = 0; r < 64; r++) begin
      fb = st[0] ^ st[2] ^ st[3] ^ st[6] ^ st[7] ^ st[8] ^ st[16] ^ st[22] ^
           st[23] ^ st[26] ^ st[30] ^ st[41] ^ st[42] ^ st[43] ^ st[46] ^ st[47];
      st = {fb, st[47:1]};
      if (r >= 32) word = {word[30:0], filter_out(st)};
    end
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  // prints are capped so a dead block cannot flood the log, counting is not
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch: %s got %h want %h", what, got, want);
  endtask

  // result side plus the watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
      if (out_strobe) begin
        if (pending_words.size() == 0) begin
          report_mismatch("keystream_word with nothing pending",
                          64'(out_keystream_word), '0);
        end else begin
          oldest_word = pending_words.pop_front();
          if (out_keystream_word !== oldest_word)
            report_mismatch("keystream_word", 64'(out_keystream_word), 64'(oldest_word));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------

  task automatic reg_write(input logic [lfkw_pkg::ADDR_W-1:0] addr,
                           input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(input logic [lfkw_pkg::ADDR_W-1:0] addr,
                                input logic [63:0] want, input string what);
    logic [63:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // stop sending and wait for every owed word
  task automatic drain_words();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // reprogram only what changed, always with the pipeline empty
  task automatic load_config(input logic [63:0] key_raw, input logic [63:0] serial_raw);
    drain_words();
    if (key_raw !== key_raw_cur) begin
      reg_write(ADDR_KEY, key_raw);
      key_raw_cur = key_raw;
      key_reg     = key_raw[47:0];
      reg_read_check(ADDR_KEY, {16'h0, key_reg}, "secret_key readback");
    end
    if (serial_raw !== serial_raw_cur) begin
      reg_write(ADDR_SERIAL, serial_raw);
      serial_raw_cur = serial_raw;
      serial_reg     = serial_raw[31:0];
      reg_read_check(ADDR_SERIAL, {32'h0, serial_reg}, "tag_serial readback");
    end
  endtask

  // --------------------------------------------------------------------------
  // nonce side
  // --------------------------------------------------------------------------

  // start stays high from one transfer to the next unless an idle cycle or a drain falls in
  task automatic send_nonce(input logic [31:0] nonce, input logic [31:0] want,
                            input bit may_idle);
    if (may_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    in_nonce <= nonce;
    do @(posedge clk); while (busy);
    pending_words.push_back(want);
  endtask

  // mostly uniform, with a share of the all-zero, all-one, one-hot and one-cold corners
  function automatic logic [31:0] pick_nonce();
    logic [31:0] onehot;
    onehot = 32'h1 << $urandom_range(31);
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return onehot;
      3:       return ~onehot;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] key_next;
    logic [63:0] serial_next;
    logic [31:0] nonce;
    bit          may_idle;

    // directed rows: reset values first, then field extremes and masking of
    // register bits above their widths; only the all-zero case is obvious
    // (zero state stays zero and the filter of zero is zero)
    dir_rows = '{
      '{64'h0, 64'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{64'h0, 64'h0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{64'h0, 64'h0, 32'h0000_0001, 1'b0, 32'h0},
      '{64'h0, 64'h0, 32'h8000_0000, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h0000_0000, 1'b0, 32'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 1'b0, 32'h0},
      '{64'h0000_0000_0000_FFFF, 64'h0, 32'h1234_5678, 1'b0, 32'h0},
      '{64'h0000_FFFF_FFFF_0000, 64'h0, 32'h1234_5678, 1'b0, 32'h0},
      '{64'h0, 64'h0000_0000_8000_0001, 32'hDEAD_BEEF, 1'b0, 32'h0},
      '{64'h0000_AAAA_AAAA_AAAA, 64'h5555_5555, 32'h5555_5555, 1'b0, 32'h0},
      '{64'h0000_5555_5555_5555, 64'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 32'h0},
      '{64'h0000_8000_0000_0001, 64'h0000_0001, 32'h0000_0001, 1'b0, 32'h0},
      '{64'h0000_0123_4567_89AB, 64'hCDEF_0123, 32'h0000_0000, 1'b0, 32'h0},
      '{64'h0000_0123_4567_89AB, 64'hCDEF_0123, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{64'h0000_0123_4567_89AB, 64'hCDEF_0123, 32'hFFFF_FFFE, 1'b0, 32'h0}
    };

    // synchronous reset, released on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].key_raw !== key_raw_cur || dir_rows[i].serial_raw !== serial_raw_cur)
        load_config(dir_rows[i].key_raw, dir_rows[i].serial_raw);
      send_nonce(dir_rows[i].nonce,
                 dir_rows[i].known ? dir_rows[i].word
                                   : predict_keystream(key_reg, serial_reg,
                                                       dir_rows[i].nonce),
                 1'b1);
    end

    // random phases: all-ones and all-zero settings first, then a zero key with a
    // random serial, then random ones, with junk in the unused upper write bits
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          key_next    = '1;
          serial_next = '1;
        end
        1: begin
          key_next    = '0;
          serial_next = '0;
        end
        2: begin
          key_next    = '0;
          serial_next = {$urandom, $urandom};
        end
        default: begin
          key_next    = {$urandom, $urandom};
          serial_next = {$urandom, $urandom};
        end
      endcase
      load_config(key_next, serial_next);
      may_idle = (p != QUIET_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // halfway through each phase the sender holds off until all words are in
        if (n == ITEMS_PER_PHASE / 2) drain_words();
        nonce = pick_nonce();
        send_nonce(nonce, predict_keystream(key_reg, serial_reg, nonce), may_idle);
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
